/* hw/rtl/binary_block_count_downsampler_core_assert.svh */
// assertion macros used by the checker file
`ifndef BINARY_BLOCK_COUNT_DOWNSAMPLER_CORE_ASSERT_SVH
`define BINARY_BLOCK_COUNT_DOWNSAMPLER_CORE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define BBCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define BBCD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hw/rtl/bbcd_pkg.sv */
// ----------------------------------------------------------------------------
// bbcd_pkg
// Shared types and constants of the binary block count downsampler.
// ----------------------------------------------------------------------------
package bbcd_pkg;

    localparam int MAX_COLS  = 4096;
    localparam int MAX_ROWS  = 4096;
    localparam int MAX_BLOCK = 16;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int BIN_W = $clog2(MAX_BLOCK);
    localparam int BS_W  = $clog2(MAX_BLOCK + 1);

    // field widths of the configuration registers and data
    localparam int THR_W   = 9;
    localparam int DIM_W   = 13;
    localparam int CFG_W   = 13;
    localparam int CNT_W   = 9;
    localparam int CELL_W  = 16;
    localparam int IDATA_W = 16;
    localparam int ODATA_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // register indexes
    localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_COLS       = 2'd2;
    localparam logic [1:0] REG_ROWS       = 2'd3;

    // reset values
    localparam int RST_BLOCK_SIZE = 2;
    localparam int RST_THRESHOLD  = 1;
    localparam int RST_COLS       = 4096;
    localparam int RST_ROWS       = 4096;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // one counted cell handed from front to back
    typedef struct packed {
        logic [COL_W-1:0] idx;
        logic             is_one;
        logic             first;
        logic             eob;
        logic             last;
    } item_t;

endpackage

/* hw/rtl/bbcd_front.sv */
// ----------------------------------------------------------------------------
// bbcd_front
// Configuration registers and raster position tracking; classifies each cell.
// ----------------------------------------------------------------------------
module bbcd_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_addr,
    input  logic [bbcd_pkg::CFG_W-1:0]        cfg_wr_data,
    input  logic                              in_valid,
    input  logic [bbcd_pkg::CELL_W-1:0]       cell_value,
    input  logic                              q_ready,
    output logic                              push,
    output bbcd_pkg::item_t                   item,
    output logic [bbcd_pkg::THR_W-1:0]        threshold
);

    localparam int CW = bbcd_pkg::COL_W + 2;
    localparam int RW = bbcd_pkg::ROW_W + 2;

    logic [bbcd_pkg::BS_W-1:0]    bsize_reg;
    logic [bbcd_pkg::THR_W-1:0]   thr_reg;
    logic [bbcd_pkg::COL_W:0]     cols_reg;
    logic [bbcd_pkg::ROW_W:0]     rows_reg;

    logic [bbcd_pkg::COL_W-1:0]   cell_col_reg, cell_col_next;
    logic [bbcd_pkg::ROW_W-1:0]   cell_row_reg, cell_row_next;
    logic [bbcd_pkg::BIN_W-1:0]   cib_reg, cib_next;
    logic [bbcd_pkg::BIN_W-1:0]   rib_reg, rib_next;
    logic [bbcd_pkg::COL_W-1:0]   block_col_reg, block_col_next;
    logic [bbcd_pkg::COL_W-1:0]   col_start_reg, col_start_next;
    logic [bbcd_pkg::ROW_W-1:0]   row_start_reg, row_start_next;

    logic [bbcd_pkg::BS_W-1:0]    bs_raw;
    logic [bbcd_pkg::DIM_W-1:0]   dim_raw;
    logic                         accept;
    logic                         in_block;
    logic                         col_end;
    logic                         row_end;
    logic                         cib_wrap;
    logic                         rib_wrap;

    assign accept  = in_valid && q_ready;
    assign bs_raw  = cfg_wr_data[bbcd_pkg::BS_W-1:0];
    assign dim_raw = cfg_wr_data[bbcd_pkg::DIM_W-1:0];

    // a block counts only when it fits whole inside the raster
    assign in_block = (CW'(col_start_reg) + CW'(bsize_reg) <= CW'(cols_reg))
                   && (RW'(row_start_reg) + RW'(bsize_reg) <= RW'(rows_reg));

    assign item.idx    = block_col_reg;
    assign item.is_one = (cell_value == bbcd_pkg::CELL_W'(1));
    assign item.first  = (cib_reg == '0) && (rib_reg == '0);
    assign item.eob    = (bbcd_pkg::BS_W'(cib_reg) == bsize_reg - 1'b1)
                      && (bbcd_pkg::BS_W'(rib_reg) == bsize_reg - 1'b1);
    // no further whole block to the right nor below
    assign item.last   = (CW'(col_start_reg) + (CW'(bsize_reg) << 1) > CW'(cols_reg))
                      && (RW'(row_start_reg) + (RW'(bsize_reg) << 1) > RW'(rows_reg));

    assign push      = accept && in_block;
    assign threshold = thr_reg;

    assign col_end  = (CW'(cell_col_reg) + CW'(1) >= CW'(cols_reg));
    assign row_end  = (RW'(cell_row_reg) + RW'(1) >= RW'(rows_reg));
    assign cib_wrap = (bbcd_pkg::BS_W'(cib_reg) + 1'b1 >= bsize_reg);
    assign rib_wrap = (bbcd_pkg::BS_W'(rib_reg) + 1'b1 >= bsize_reg);

    always_comb
    begin
        cell_col_next  = cell_col_reg;
        cell_row_next  = cell_row_reg;
        cib_next       = cib_reg;
        rib_next       = rib_reg;
        block_col_next = block_col_reg;
        col_start_next = col_start_reg;
        row_start_next = row_start_reg;
        if (col_end)
        begin
            cell_col_next  = '0;
            cib_next       = '0;
            block_col_next = '0;
            col_start_next = '0;
            if (row_end)
            begin
                cell_row_next  = '0;
                rib_next       = '0;
                row_start_next = '0;
            end
            else
            begin
                cell_row_next = cell_row_reg + 1'b1;
                if (rib_wrap)
                begin
                    rib_next       = '0;
                    row_start_next = cell_row_reg + 1'b1;
                end
                else
                begin
                    rib_next = rib_reg + 1'b1;
                end
            end
        end
        else
        begin
            cell_col_next = cell_col_reg + 1'b1;
            if (cib_wrap)
            begin
                cib_next       = '0;
                block_col_next = block_col_reg + 1'b1;
                col_start_next = cell_col_reg + 1'b1;
            end
            else
            begin
                cib_next = cib_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsize_reg     <= bbcd_pkg::BS_W'(bbcd_pkg::RST_BLOCK_SIZE);
            thr_reg       <= bbcd_pkg::THR_W'(bbcd_pkg::RST_THRESHOLD);
            cols_reg      <= (bbcd_pkg::COL_W + 1)'(bbcd_pkg::RST_COLS);
            rows_reg      <= (bbcd_pkg::ROW_W + 1)'(bbcd_pkg::RST_ROWS);
            cell_col_reg  <= '0;
            cell_row_reg  <= '0;
            cib_reg       <= '0;
            rib_reg       <= '0;
            block_col_reg <= '0;
            col_start_reg <= '0;
            row_start_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                bbcd_pkg::REG_BLOCK_SIZE:
                begin
                    if (bs_raw == '0)
                        bsize_reg <= bbcd_pkg::BS_W'(1);
                    else if (32'(bs_raw) > bbcd_pkg::MAX_BLOCK)
                        bsize_reg <= bbcd_pkg::BS_W'(bbcd_pkg::MAX_BLOCK);
                    else
                        bsize_reg <= bs_raw;
                end
                bbcd_pkg::REG_THRESHOLD:
                    thr_reg <= cfg_wr_data[bbcd_pkg::THR_W-1:0];
                bbcd_pkg::REG_COLS:
                begin
                    if (dim_raw == '0)
                        cols_reg <= (bbcd_pkg::COL_W + 1)'(1);
                    else if (32'(dim_raw) > bbcd_pkg::MAX_COLS)
                        cols_reg <= (bbcd_pkg::COL_W + 1)'(bbcd_pkg::MAX_COLS);
                    else
                        cols_reg <= (bbcd_pkg::COL_W + 1)'(dim_raw);
                end
                bbcd_pkg::REG_ROWS:
                begin
                    if (dim_raw == '0)
                        rows_reg <= (bbcd_pkg::ROW_W + 1)'(1);
                    else if (32'(dim_raw) > bbcd_pkg::MAX_ROWS)
                        rows_reg <= (bbcd_pkg::ROW_W + 1)'(bbcd_pkg::MAX_ROWS);
                    else
                        rows_reg <= (bbcd_pkg::ROW_W + 1)'(dim_raw);
                end
                default:
                    thr_reg <= thr_reg;
            endcase
            // any write restarts the frame
            cell_col_reg  <= '0;
            cell_row_reg  <= '0;
            cib_reg       <= '0;
            rib_reg       <= '0;
            block_col_reg <= '0;
            col_start_reg <= '0;
            row_start_reg <= '0;
        end
        else if (accept)
        begin
            cell_col_reg  <= cell_col_next;
            cell_row_reg  <= cell_row_next;
            cib_reg       <= cib_next;
            rib_reg       <= rib_next;
            block_col_reg <= block_col_next;
            col_start_reg <= col_start_next;
            row_start_reg <= row_start_next;
        end
    end

endmodule

/* hw/rtl/bbcd_queue.sv */
// ----------------------------------------------------------------------------
// bbcd_queue
// Short FIFO of classified cells between the front and the counter back end.
// ----------------------------------------------------------------------------
module bbcd_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bbcd_pkg::item_t push_item,
    output logic            ready,
    input  logic            pop,
    output logic            head_valid,
    output bbcd_pkg::item_t head_item
);

    bbcd_pkg::item_t                  slot_reg [bbcd_pkg::Q_DEPTH];
    logic [bbcd_pkg::QPTR_W-1:0]      wptr_reg;
    logic [bbcd_pkg::QPTR_W-1:0]      rptr_reg;
    logic [bbcd_pkg::QCNT_W-1:0]      count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign ready      = (count_reg != bbcd_pkg::QCNT_W'(bbcd_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rptr_reg];
    assign do_push    = push && ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (32'(wptr_reg) == bbcd_pkg::Q_DEPTH - 1) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (32'(rptr_reg) == bbcd_pkg::Q_DEPTH - 1) ? '0 : rptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* hw/rtl/bbcd_back.sv */
// ----------------------------------------------------------------------------
// bbcd_back
// Per block column count memory, read-modify-write pipeline and output stage.
// ----------------------------------------------------------------------------
module bbcd_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  bbcd_pkg::item_t             head_item,
    output logic                        pop,
    input  logic [bbcd_pkg::THR_W-1:0]  threshold,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_bit,
    output logic                        out_last
);

    logic [bbcd_pkg::CNT_W-1:0] mem [bbcd_pkg::MAX_COLS];
    logic [bbcd_pkg::CNT_W-1:0] rdata_reg;

    logic                       s1_valid_reg;
    bbcd_pkg::item_t            s1_item_reg;
    logic                       fwd_reg;
    logic [bbcd_pkg::CNT_W-1:0] fwd_val_reg;

    logic                       out_valid_reg;
    logic                       out_bit_reg;
    logic                       out_last_reg;

    logic                       advance;
    logic [bbcd_pkg::CNT_W-1:0] base;
    logic [bbcd_pkg::CNT_W-1:0] new_count;
    logic [bbcd_pkg::CNT_W-1:0] wr_val;

    // a result waits only while the output register is occupied and not taken
    assign advance = s1_valid_reg
                  && (!s1_item_reg.eob || !out_valid_reg || out_ready);
    assign pop     = head_valid && (!s1_valid_reg || advance);

    // first cell of a block starts from zero, so stale entries never matter
    always_comb
    begin
        if (s1_item_reg.first)
            base = '0;
        else if (fwd_reg)
            base = fwd_val_reg;
        else
            base = rdata_reg;
        new_count = (s1_item_reg.is_one && base != bbcd_pkg::CNT_MAX)
                  ? base + 1'b1 : base;
        wr_val    = s1_item_reg.eob ? '0 : new_count;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            mem[s1_item_reg.idx] <= wr_val;
        if (pop)
            rdata_reg <= mem[head_item.idx];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg <= head_item;
            // write to the same column in this cycle is not yet in the read data
            fwd_reg     <= advance && (head_item.idx == s1_item_reg.idx);
            fwd_val_reg <= wr_val;
        end
        if (advance && s1_item_reg.eob)
        begin
            out_bit_reg  <= (new_count >= threshold);
            out_last_reg <= s1_item_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (advance && s1_item_reg.eob)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_bit   = out_bit_reg;
    assign out_last  = out_last_reg;

endmodule

/* hw/rtl/binary_block_count_downsampler_core.sv */
// ----------------------------------------------------------------------------
// binary_block_count_downsampler_core
// Counts cells equal to one in each square block and emits one threshold bit.
// ----------------------------------------------------------------------------
// Takes one raster cell per clock unless the output stalls; a block's bit
// passes the queue, read and output registers after its bottom-right cell is
// accepted. The rate is set by the count memory (one entry per block column,
// one read and one write port): every counted cell does one
// read-modify-write, with the write of the previous cell forwarded when both
// hit the same column. No clearing pass is needed after reset or a register
// write; a block's count starts from zero at its top-left cell. A register
// write restarts the frame and must be made while no cell is in flight.
module binary_block_count_downsampler_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_addr,
    input  logic [bbcd_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bbcd_pkg::IDATA_W-1:0]   s_axis_tdata,   // [15:0] cell_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bbcd_pkg::ODATA_W-1:0]   m_axis_tdata,   // [0] out_bit, [7:1] zero
    output logic                           m_axis_tlast    // last_output
);

    logic                       push;
    logic                       q_ready;
    logic                       pop;
    logic                       head_valid;
    bbcd_pkg::item_t            push_item;
    bbcd_pkg::item_t            head_item;
    logic [bbcd_pkg::THR_W-1:0] threshold;
    logic                       out_bit;

    bbcd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .cell_value  (s_axis_tdata[bbcd_pkg::CELL_W-1:0]),
        .q_ready     (q_ready),
        .push        (push),
        .item        (push_item),
        .threshold   (threshold)
    );

    bbcd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    bbcd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .threshold  (threshold),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_bit    (out_bit),
        .out_last   (m_axis_tlast)
    );

    assign s_axis_tready = q_ready;
    assign m_axis_tdata  = {(bbcd_pkg::ODATA_W - 1)'(0), out_bit};

endmodule

/* hw/rtl/bbcd_checker.sv */
// ----------------------------------------------------------------------------
// bbcd_checker
// Port level checks of the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_block_count_downsampler_core_assert.svh"

module bbcd_port_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [bbcd_pkg::ODATA_W-1:0]   m_axis_tdata,
    input  logic                           m_axis_tlast
);

    // a stalled result keeps valid, bit and last flag
    `BBCD_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled output transfer changed")

    // pad bits above out_bit stay zero
    `BBCD_NEVER(a_out_pad, m_axis_tvalid && (m_axis_tdata[bbcd_pkg::ODATA_W-1:1] != '0), "output pad bits not zero")

    // input back-pressure only arises from a stalled output
    `BBCD_ASSERT(a_bp_origin, !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready), "input stalled without output back-pressure")

endmodule

bind binary_block_count_downsampler_core bbcd_port_checker u_bbcd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
